>>> design/fdez_pkg.sv
`timescale 1ns / 1ps

package fdez_pkg;

    // Default sizes of the row and plane stores
    localparam int DEF_MAX_ROW_CELLS = 256;
    localparam int DEF_MAX_ROWS      = 256;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_PLANE = 1'b1;

    localparam logic [CFG_W-1:0] ROW_LENGTH_RESET     = 9'd256;
    localparam logic [CFG_W-1:0] ROWS_PER_PLANE_RESET = 9'd256;

    // One grid cell as it enters the update pipeline
    typedef struct packed {
        logic [DATA_W-1:0] ez_old;
        logic [DATA_W-1:0] coef_keep;
        logic [DATA_W-1:0] coef_curl;
        logic [DATA_W-1:0] hy_here;
        logic [DATA_W-1:0] hx_here;
        logic [DATA_W-1:0] inv_dx;
        logic [DATA_W-1:0] inv_dy;
    } fdez_cell_t;

    // Neighbor values read from the stores, aligned with the first stage
    typedef struct packed {
        logic [DATA_W-1:0] hx_prev;
        logic [DATA_W-1:0] hy_prev;
        logic              halo;
    } fdez_prev_t;

endpackage

>>> design/fdez_stores.sv
`timescale 1ns / 1ps

module fdez_stores #(
    parameter int MAX_ROW_CELLS = fdez_pkg::DEF_MAX_ROW_CELLS,
    parameter int MAX_ROWS      = fdez_pkg::DEF_MAX_ROWS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic                          frame_start,
    input  logic [fdez_pkg::CFG_W-1:0]    row_length,
    input  logic [fdez_pkg::CFG_W-1:0]    rows_per_plane,
    input  logic [fdez_pkg::DATA_W-1:0]   hx_here,
    input  logic [fdez_pkg::DATA_W-1:0]   hy_here,
    output fdez_pkg::fdez_prev_t          prev
);

    localparam int CW          = $clog2(MAX_ROW_CELLS);
    localparam int RW          = $clog2(MAX_ROWS);
    localparam int LW          = CW + 1;
    localparam int PW          = RW + 1;
    localparam int PLANE_DEPTH = MAX_ROWS * (2 ** CW);

    logic [CW-1:0] cell_reg, cell_next, cur_cell;
    logic [RW-1:0] row_reg, row_next, cur_row;
    logic          first_reg, first_next, cur_first;
    logic [LW-1:0] rl_eff, cell_p1;
    logic [PW-1:0] rp_eff, row_p1;
    logic [RW+CW-1:0] plane_addr;

    logic [fdez_pkg::DATA_W-1:0] hx_mem [MAX_ROW_CELLS];
    logic [fdez_pkg::DATA_W-1:0] hy_mem [PLANE_DEPTH];
    logic [fdez_pkg::DATA_W-1:0] hx_rd_reg, hy_rd_reg;
    logic                        halo_reg;

    // Clamp the lengths to their legal ranges
    always_comb begin
        if (row_length == '0) begin
            rl_eff = LW'(1);
        end else if (32'(row_length) > MAX_ROW_CELLS) begin
            rl_eff = LW'(MAX_ROW_CELLS);
        end else begin
            rl_eff = LW'(row_length);
        end
        if (rows_per_plane < 9'd2) begin
            rp_eff = PW'(2);
        end else if (32'(rows_per_plane) > MAX_ROWS) begin
            rp_eff = PW'(MAX_ROWS);
        end else begin
            rp_eff = PW'(rows_per_plane);
        end
    end

    // Position of the current item; a frame start restarts the pass
    always_comb begin
        cur_cell   = frame_start ? '0 : cell_reg;
        cur_row    = frame_start ? '0 : row_reg;
        cur_first  = frame_start | first_reg;
        plane_addr = {cur_row, cur_cell};
        cell_p1    = {1'b0, cur_cell} + LW'(1);
        row_p1     = {1'b0, cur_row} + PW'(1);
        cell_next  = cell_p1[CW-1:0];
        row_next   = cur_row;
        first_next = cur_first;
        if (cell_p1 >= rl_eff) begin
            cell_next = '0;
            if (row_p1 >= rp_eff) begin
                row_next   = '0;
                first_next = 1'b0;
            end else begin
                row_next = row_p1[RW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg  <= '0;
            row_reg   <= '0;
            first_reg <= 1'b1;
        end else if (accept) begin
            cell_reg  <= cell_next;
            row_reg   <= row_next;
            first_reg <= first_next;
        end
    end

    // Read the old entry, then overwrite it with this item's value
    always_ff @(posedge aclk) begin
        if (accept) begin
            hx_rd_reg        <= hx_mem[cur_cell];
            hx_mem[cur_cell] <= hx_here;
            halo_reg         <= cur_first || (cur_row == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hy_rd_reg          <= hy_mem[plane_addr];
            hy_mem[plane_addr] <= hy_here;
        end
    end

    assign prev = '{hx_prev: hx_rd_reg, hy_prev: hy_rd_reg, halo: halo_reg};

    a_first_only_on_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(first_reg) |-> $past(accept && frame_start))
        else $error("first-plane flag set without a frame start");

    a_row_holds_mid_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !frame_start && (cell_next != '0))
        |=> (row_reg == $past(row_reg)) && (first_reg == $past(first_reg)))
        else $error("row position moved inside a row");

endmodule

>>> design/fdez_datapath.sv
`timescale 1ns / 1ps

module fdez_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fdez_pkg::fdez_cell_t          cell_in,
    input  fdez_pkg::fdez_prev_t          prev,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fdez_pkg::DATA_W-1:0]   ez_new,
    output logic                          updated
);

    localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    logic accept;

    fdez_pkg::fdez_cell_t c1_reg;

    logic signed [31:0] ez2_reg, k1_2_reg, k2_2_reg, rx2_reg, ry2_reg;
    logic signed [32:0] dy2_reg, dx2_reg;
    logic               halo2_reg;

    logic signed [64:0] px3_reg, py3_reg;
    logic signed [63:0] t1_3_reg;
    logic signed [31:0] ez3_reg, k2_3_reg;
    logic               halo3_reg;

    logic signed [31:0] curl4_reg, ez4_reg, k2_4_reg;
    logic signed [47:0] t1q4_reg;
    logic               halo4_reg;

    logic signed [63:0] t2_5_reg;
    logic signed [47:0] t1q5_reg;
    logic signed [31:0] ez5_reg;
    logic               halo5_reg;

    logic [31:0] ez_new_reg;
    logic        upd_reg;

    logic signed [48:0] px_q, py_q;
    logic signed [49:0] curl_wide;
    logic signed [48:0] sum_wide;

    // Each stage moves when it is empty or the next one moves
    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign accept   = in_valid && rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    always_comb begin
        px_q      = $signed(px3_reg[64:16]);
        py_q      = $signed(py3_reg[64:16]);
        curl_wide = 50'(px_q) - 50'(py_q);
        sum_wide  = 49'(t1q5_reg) + 49'($signed(t2_5_reg[63:16]));
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            c1_reg <= cell_in;
        end
        // Backward differences against the stored neighbors
        if (rdy2 && v1_reg) begin
            ez2_reg   <= $signed(c1_reg.ez_old);
            k1_2_reg  <= $signed(c1_reg.coef_keep);
            k2_2_reg  <= $signed(c1_reg.coef_curl);
            rx2_reg   <= $signed(c1_reg.inv_dx);
            ry2_reg   <= $signed(c1_reg.inv_dy);
            dy2_reg   <= 33'($signed(c1_reg.hy_here)) - 33'($signed(prev.hy_prev));
            dx2_reg   <= 33'($signed(c1_reg.hx_here)) - 33'($signed(prev.hx_prev));
            halo2_reg <= prev.halo;
        end
        if (rdy3 && v2_reg) begin
            px3_reg   <= rx2_reg * dy2_reg;
            py3_reg   <= ry2_reg * dx2_reg;
            t1_3_reg  <= k1_2_reg * ez2_reg;
            ez3_reg   <= ez2_reg;
            k2_3_reg  <= k2_2_reg;
            halo3_reg <= halo2_reg;
        end
        // Floor each scaled product before the difference
        if (rdy4 && v3_reg) begin
            curl4_reg <= sat32(64'(curl_wide));
            t1q4_reg  <= $signed(t1_3_reg[63:16]);
            ez4_reg   <= ez3_reg;
            k2_4_reg  <= k2_3_reg;
            halo4_reg <= halo3_reg;
        end
        if (rdy5 && v4_reg) begin
            t2_5_reg  <= k2_4_reg * curl4_reg;
            t1q5_reg  <= t1q4_reg;
            ez5_reg   <= ez4_reg;
            halo5_reg <= halo4_reg;
        end
        // Halo cells pass ez through unchanged
        if (rdy6 && v5_reg) begin
            ez_new_reg <= halo5_reg ? ez5_reg : sat32(64'(sum_wide));
            upd_reg    <= !halo5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign ez_new    = ez_new_reg;
    assign updated   = upd_reg;

    logic deliver;
    logic [2:0] fill;
    assign deliver = v6_reg && out_ready;
    assign fill    = 3'($countones({v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg}));

    a_fill_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !deliver) |=> (fill == $past(fill) + 3'd1))
        else $error("accepted item lost in the pipeline");

    a_fill_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (!accept && deliver) |=> (fill == $past(fill) - 3'd1))
        else $error("item repeated or invented in the pipeline");

    a_fill_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept == deliver) |=> (fill == $past(fill)))
        else $error("pipeline occupancy changed without a handshake");

endmodule

>>> design/fdtd_ez_field_update_top.sv
`timescale 1ns / 1ps
// Ez update for a 2D Yee grid, one cell per item, signed Q16.16 throughout.
// An accepted item passes through every pipeline stage, each registered, before it is offered on m_.
// Throughput: one item per clock unless m_tready stalls; the six-stage pipeline and
// the single-port row and plane stores (read and write in the accept cycle) set that figure.
// Reset (aresetn low, synchronous) clears positions, sets the first-plane
// flag, restores both registers and empties the pipeline; stores keep content.

module fdtd_ez_field_update_top #(
    parameter int MAX_ROW_CELLS = fdez_pkg::DEF_MAX_ROW_CELLS,
    parameter int MAX_ROWS      = fdez_pkg::DEF_MAX_ROWS
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // Cell input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // ez_old, coef_keep, coef_curl, hy_here, hx_here, inv_dx, inv_dy (32 each)
    input  logic [7*fdez_pkg::DATA_W-1:0]    s_tdata,
    // frame_start
    input  logic                             s_tuser,

    // Result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // ez_new
    output logic [fdez_pkg::DATA_W-1:0]      m_tdata,
    // updated
    output logic                             m_tuser,

    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fdez_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fdez_pkg::CFG_W-1:0]       cfg_data
);

    localparam int W = fdez_pkg::DATA_W;

    logic [fdez_pkg::CFG_W-1:0] row_length_reg;
    logic [fdez_pkg::CFG_W-1:0] rows_per_plane_reg;

    fdez_pkg::fdez_cell_t grid_cell;
    fdez_pkg::fdez_prev_t prev;
    logic                 in_accept;

    // Registers take a write in any cycle; the user must keep the block idle when they change (not enforced here)
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg     <= fdez_pkg::ROW_LENGTH_RESET;
            rows_per_plane_reg <= fdez_pkg::ROWS_PER_PLANE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                fdez_pkg::REG_ROW_LENGTH:     row_length_reg     <= cfg_data;
                fdez_pkg::REG_ROWS_PER_PLANE: rows_per_plane_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the cell fields from the lowest bits up
    assign grid_cell.ez_old    = s_tdata[0*W +: W];
    assign grid_cell.coef_keep = s_tdata[1*W +: W];
    assign grid_cell.coef_curl = s_tdata[2*W +: W];
    assign grid_cell.hy_here   = s_tdata[3*W +: W];
    assign grid_cell.hx_here   = s_tdata[4*W +: W];
    assign grid_cell.inv_dx    = s_tdata[5*W +: W];
    assign grid_cell.inv_dy    = s_tdata[6*W +: W];

    // The stores read and write in the same cycle the pipeline takes the item
    assign in_accept = s_tvalid && s_tready;

    // Position tracking and neighbor stores; their read data is stage one
    fdez_stores #(
        .MAX_ROW_CELLS (MAX_ROW_CELLS),
        .MAX_ROWS      (MAX_ROWS)
    ) u_stores (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (in_accept),
        .frame_start    (s_tuser),
        .row_length     (row_length_reg),
        .rows_per_plane (rows_per_plane_reg),
        .hx_here        (grid_cell.hx_here),
        .hy_here        (grid_cell.hy_here),
        .prev           (prev)
    );

    // Differences, products, curl, scaling and final saturation
    fdez_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cell_in   (grid_cell),
        .prev      (prev),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ez_new    (m_tdata),
        .updated   (m_tuser)
    );

endmodule

>>> tb/fdtd_ez_field_update_checker.sv
`timescale 1ns / 1ps

module fdtd_ez_field_update_checker
    import fdez_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7*DATA_W-1:0]    s_tdata,
    input  logic                   s_tuser,

    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [DATA_W-1:0]      m_tdata,
    input  logic                   m_tuser,

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,

    output int                     mismatch_count,
    output int                     expected_left,
    output int                     cells_checked,
    output int                     updates_seen
);

    localparam int ROW_CELLS  = DEF_MAX_ROW_CELLS;
    localparam int PLANE_ROWS = DEF_MAX_ROWS;
    localparam int SHOW_LIMIT = 200;

    localparam logic signed [79:0] TOP32 = 80'sd2147483647;
    localparam logic signed [79:0] BOT32 = -80'sd2147483648;

    typedef struct packed {
        logic [DATA_W-1:0] ez_new;
        logic              updated;
    } ez_result_t;

    // Shadow copy of the grid state
    logic [DATA_W-1:0] hx_prev_row   [ROW_CELLS];
    logic [DATA_W-1:0] hy_prev_plane [ROW_CELLS*PLANE_ROWS];
    int                cell_pos;
    int                row_pos;
    logic              first_plane;
    logic [CFG_W-1:0]  row_len_reg;
    logic [CFG_W-1:0]  rows_reg;

    ez_result_t ez_due[$];
    ez_result_t want;
    fdez_cell_t cell_in;

    initial begin
        mismatch_count = 0;
        cells_checked  = 0;
        updates_seen   = 0;
        expected_left  = 0;
    end

    function automatic logic signed [31:0] clip32(input logic signed [79:0] v);
        if (v > TOP32)
            return 32'sh7FFFFFFF;
        if (v < BOT32)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Work out one cell and advance the grid position
    function automatic ez_result_t update_ez(input fdez_cell_t c, input logic frame_start);
        int                 rl;
        int                 rp;
        int                 col;
        int                 row;
        int                 pidx;
        logic signed [79:0] dy;
        logic signed [79:0] dx;
        logic signed [79:0] px;
        logic signed [79:0] py;
        logic signed [79:0] curl;
        logic signed [79:0] t1;
        logic signed [79:0] t2;
        ez_result_t         r;

        rl = (row_len_reg == 0) ? 1 : (row_len_reg > ROW_CELLS) ? ROW_CELLS : int'(row_len_reg);
        rp = (rows_reg < 2) ? 2 : (rows_reg > PLANE_ROWS) ? PLANE_ROWS : int'(rows_reg);

        if (frame_start) begin
            cell_pos    = 0;
            row_pos     = 0;
            first_plane = 1'b1;
        end

        col  = (cell_pos < ROW_CELLS) ? cell_pos : 0;
        row  = (row_pos < PLANE_ROWS) ? row_pos : 0;
        pidx = row * ROW_CELLS + col;

        r.ez_new  = c.ez_old;
        r.updated = 1'b0;
        if (!first_plane && row != 0) begin
            dy   = $signed(c.hy_here) - $signed(hy_prev_plane[pidx]);
            dx   = $signed(c.hx_here) - $signed(hx_prev_row[col]);
            px   = ($signed(c.inv_dx) * dy) >>> 16;
            py   = ($signed(c.inv_dy) * dx) >>> 16;
            curl = clip32(px - py);
            t1   = ($signed(c.coef_keep) * $signed(c.ez_old)) >>> 16;
            t2   = ($signed(c.coef_curl) * curl) >>> 16;
            r.ez_new  = clip32(t1 + t2);
            r.updated = 1'b1;
        end

        hx_prev_row[col]    = c.hx_here;
        hy_prev_plane[pidx] = c.hy_here;

        cell_pos = col + 1;
        if (cell_pos >= rl) begin
            cell_pos = 0;
            row_pos  = row + 1;
            if (row_pos >= rp) begin
                row_pos     = 0;
                first_plane = 1'b0;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cell_pos    = 0;
            row_pos     = 0;
            first_plane = 1'b1;
            row_len_reg = ROW_LENGTH_RESET;
            rows_reg    = ROWS_PER_PLANE_RESET;
            ez_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_ROW_LENGTH)
                    row_len_reg = cfg_data;
                else if (cfg_index == REG_ROWS_PER_PLANE)
                    rows_reg = cfg_data;
            end

            if (s_tvalid && s_tready) begin
                cell_in.ez_old    = s_tdata[0*DATA_W +: DATA_W];
                cell_in.coef_keep = s_tdata[1*DATA_W +: DATA_W];
                cell_in.coef_curl = s_tdata[2*DATA_W +: DATA_W];
                cell_in.hy_here   = s_tdata[3*DATA_W +: DATA_W];
                cell_in.hx_here   = s_tdata[4*DATA_W +: DATA_W];
                cell_in.inv_dx    = s_tdata[5*DATA_W +: DATA_W];
                cell_in.inv_dy    = s_tdata[6*DATA_W +: DATA_W];
                ez_due.push_back(update_ez(cell_in, s_tuser));
            end

            if (m_tvalid && m_tready) begin
                if (ez_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                        $display("%0t: unexpected result, expected none, actual ez_new=%h updated=%b",
                                 $time, m_tdata, m_tuser);
                end else begin
                    want = ez_due.pop_front();
                    cells_checked++;
                    if (want.updated)
                        updates_seen++;
                    if (m_tdata !== want.ez_new) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOW_LIMIT)
                            $display("%0t: ez_new mismatch, expected %h, actual %h",
                                     $time, want.ez_new, m_tdata);
                    end
                    if (m_tuser !== want.updated) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOW_LIMIT)
                            $display("%0t: updated mismatch, expected %b, actual %b",
                                     $time, want.updated, m_tuser);
                    end
                end
            end
        end
        expected_left <= ez_due.size();
    end

endmodule

>>> tb/fdtd_ez_field_update_top_tb.sv
`timescale 1ns / 1ps

module fdtd_ez_field_update_top_tb;
    import fdez_pkg::*;

    localparam int CELL_TARGET = 2000;
    localparam int QUIET_LIMIT = 2000;    // cycles with no handshake at all
    localparam int DRAIN_TAIL  = 8;       // pipeline is six stages deep

    localparam logic [DATA_W-1:0] MAXV = 32'h7FFFFFFF;
    localparam logic [DATA_W-1:0] MINV = 32'h80000000;
    localparam logic [DATA_W-1:0] ONE  = 32'h00010000;    // 1.0 in Q16.16
    localparam logic [DATA_W-1:0] NEG1 = 32'hFFFFFFFF;    // -1 LSB

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7*DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;

    int mismatch_count;
    int expected_left;
    int cells_checked;
    int updates_seen;

    int cells_sent   = 0;
    int burst_left   = 0;
    int quiet_cycles = 0;

    // Receiver stall pattern state
    int stall_mode = 0;
    int mode_left  = 0;
    int run_left   = 0;

    always #5 aclk = ~aclk;

    fdtd_ez_field_update_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fdtd_ez_field_update_checker ez_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .expected_left  (expected_left),
        .cells_checked  (cells_checked),
        .updates_seen   (updates_seen)
    );

    // Receiver: switch among stall patterns at random intervals.
    // Mode 0 never stalls, 1 stalls lightly, 2 heavily, 3 in runs.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(50, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 7);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (run_left == 0) begin
                    m_tready <= ~m_tready;
                    run_left <= m_tready ? $urandom_range(1, 12) : $urandom_range(1, 8);
                end else begin
                    run_left <= run_left - 1;
                end
            end
        endcase
    end

    // Watchdog: give up when nothing moves on any channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog expired, no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("fdtd_ez_field_update_top test failed");
            $finish;
        end
    end

    function automatic fdez_cell_t mk(input logic [DATA_W-1:0] ez, input logic [DATA_W-1:0] k1,
                                      input logic [DATA_W-1:0] k2, input logic [DATA_W-1:0] hy,
                                      input logic [DATA_W-1:0] hx, input logic [DATA_W-1:0] rx,
                                      input logic [DATA_W-1:0] ry);
        fdez_cell_t c;
        c.ez_old    = ez;
        c.coef_keep = k1;
        c.coef_curl = k2;
        c.hy_here   = hy;
        c.hx_here   = hx;
        c.inv_dx    = rx;
        c.inv_dy    = ry;
        return c;
    endfunction

    // Mix full-range words, extremes and small values near the origin so
    // that many updates stay clear of saturation.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2: begin
                case ($urandom_range(0, 3))
                    0:       return MAXV;
                    1:       return MINV;
                    2:       return '0;
                    default: return NEG1;
                endcase
            end
            default: return $urandom_range(0, 2**19) - 2**18;
        endcase
    endfunction

    function automatic fdez_cell_t random_cell();
        return mk(pick_value(), pick_value(), pick_value(), pick_value(),
                  pick_value(), pick_value(), pick_value());
    endfunction

    // Offer one item and hold it until it is taken. Between bursts drop
    // tvalid for a random gap.
    task automatic send_cell(input fdez_cell_t c, input logic frame_start);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {c.inv_dy, c.inv_dx, c.hx_here, c.hy_here,
                     c.coef_curl, c.coef_keep, c.ez_old};
        s_tuser  <= frame_start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cells_sent++;
    endtask

    // Stop sending and wait until every pending result has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // One grid phase: drain, program the shape, then stream random cells.
    // With restart the first cell opens a new pass; with noise a stray
    // frame start lands now and then in the middle of a pass.
    task automatic run_grid(input int rl, input int rp, input int cells,
                            input bit restart, input bit noise);
        logic fs;
        drain();
        write_reg(REG_ROW_LENGTH, CFG_W'(rl));
        write_reg(REG_ROWS_PER_PLANE, CFG_W'(rp));
        for (int i = 0; i < cells; i++) begin
            if (cells >= 200 && i == cells / 2)
                drain();
            fs = (restart && i == 0) || (noise && $urandom_range(0, 199) == 0);
            send_cell(random_cell(), fs);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed pass on a 2-cell by 3-row grid: the first plane and each
        // row 0 are halo; later cells hit both saturation limits, floor
        // rounding, plain copies and alternating bit patterns.
        drain();
        write_reg(REG_ROW_LENGTH, CFG_W'(2));
        write_reg(REG_ROWS_PER_PLANE, CFG_W'(3));
        send_cell(mk(MAXV, MINV, MINV, MINV, MAXV, MINV, MINV), 1'b1);
        send_cell(mk(MINV, MAXV, MAXV, MAXV, MINV, MAXV, MAXV), 1'b0);
        send_cell(mk('0, '0, '0, MINV, '0, '0, '0), 1'b0);
        send_cell(mk(NEG1, NEG1, NEG1, MAXV, '0, NEG1, NEG1), 1'b0);
        send_cell(mk(ONE, ONE, ONE, '0, MINV, ONE, ONE), 1'b0);
        send_cell(mk('0, '0, '0, '0, MAXV, '0, '0), 1'b0);
        send_cell(mk('0, '0, '0, '0, MINV, '0, '0), 1'b0);
        send_cell(mk('0, '0, '0, 32'd1, MAXV, '0, '0), 1'b0);
        // Curl and result saturate high, then low
        send_cell(mk(MAXV, MAXV, MAXV, MAXV, MINV, MAXV, MAXV), 1'b0);
        send_cell(mk(MINV, MAXV, MAXV, MINV, MAXV, MAXV, MINV), 1'b0);
        send_cell(mk('0, '0, MINV, '0, MAXV, '0, MINV), 1'b0);
        // Both products round toward minus infinity
        send_cell(mk(NEG1, ONE, NEG1, 32'd1, MAXV, ONE, '0), 1'b0);
        send_cell(mk(32'h12345678, '0, '0, 32'h00030000, 32'h00020000, '0, '0), 1'b0);
        send_cell(mk(32'hEDCBA988, '0, '0, 32'hFFFD0000, 32'hFFFE0000, '0, '0), 1'b0);
        send_cell(mk(32'h00030000, ONE, ONE, MAXV, 32'h00020000, ONE, ONE), 1'b0);
        send_cell(mk(32'h00018000, 32'hFFFF0000, 32'h00008000, MINV, 32'hFFFE0000,
                     32'h00020000, 32'h00040000), 1'b0);
        send_cell(mk(32'h7FFF0000, 32'h00020000, ONE, ONE, 32'h00030000, ONE, ONE), 1'b0);
        send_cell(mk(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                     32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA), 1'b0);
        // Frame start in the middle of a pass
        send_cell(mk(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                     32'h55555555, 32'hAAAAAAAA, 32'h55555555), 1'b1);
        send_cell(mk(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                     32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA), 1'b0);

        // Smallest grid, then register values below range (act as 1 and 2)
        run_grid(1, 2, 60, 1'b1, 1'b1);
        run_grid(0, 1, 40, 1'b1, 1'b1);
        // Widest rows: a length above range acts as full width; one pause
        // in the middle waits for every result
        run_grid(300, 2, 1060, 1'b1, 1'b1);
        // Deepest planes, exactly at and above range
        run_grid(1, 256, 300, 1'b1, 1'b1);
        run_grid(1, 400, 270, 1'b1, 1'b1);
        // Shrink both registers past the plane's first row without a
        // restart: the counters sit beyond the new lengths and must wrap
        run_grid(8, 6, 77, 1'b1, 1'b0);
        run_grid(3, 2, 30, 1'b0, 1'b0);

        // Random small grids until the cell budget is spent
        while (cells_sent < CELL_TARGET)
            run_grid($urandom_range(1, 12), $urandom_range(2, 8), $urandom_range(40, 120),
                     1'b1, 1'b1);

        drain();

        $display("Covered %0d cells: %0d updated, %0d halo pass-throughs",
                 cells_checked, updates_seen, cells_checked - updates_seen);
        $display("Grids from 1x2 up to 256-wide and 256-deep, out-of-range lengths, ",
                 "stray frame starts and a shrink in mid pass");
        if (mismatch_count == 0 && expected_left == 0)
            $display("fdtd_ez_field_update_top test passed");
        else
            $display("fdtd_ez_field_update_top test failed");
        $finish;
    end

endmodule

>>> fdtd_ez_field_update_top.f
design/fdez_pkg.sv
design/fdez_stores.sv
design/fdez_datapath.sv
design/fdtd_ez_field_update_top.sv
tb/fdtd_ez_field_update_checker.sv
tb/fdtd_ez_field_update_top_tb.sv
